>>> rtl/core/kwat_pkg.sv
// ----------------------------------------------------------------------------
// kwat_pkg: shared types for the keyed area-weighted average table
// Holds the command codes, the packet that walks the cell chain and the
// control state encoding of the top level.
// ----------------------------------------------------------------------------
package kwat_pkg;

    // Command codes carried in the input tuser field.
    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Packet handed from cell to cell. For an add the sums fields carry the
    // scrap area and both products; after a query hit they carry the entry's sums.
    typedef struct packed {
        logic        vld;
        cmd_t        cmd;
        logic [63:0] key;
        logic        done;
        logic        found;
        logic [39:0] area;
        logic [63:0] wc;
        logic [63:0] ws;
    } pkt_t;

    // Top-level control states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_HOLD
    } state_t;

    localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] OUT_MIN = 24'sh800000;

endpackage

>>> rtl/core/kwat_cell.sv
// ----------------------------------------------------------------------------
// kwat_cell: one table entry of the cell chain
// Holds one key and its sums, updates them from the passing packet and
// registers the packet for the next cell.
// ----------------------------------------------------------------------------
module kwat_cell
(
    input  logic           clk,
    input  logic           rst_n,
    input  kwat_pkg::pkt_t pkt_in,
    output kwat_pkg::pkt_t pkt_out
);
    import kwat_pkg::*;

    logic        valid_reg, valid_next;
    logic [63:0] key_reg, key_next;
    logic [39:0] area_reg, area_next;
    logic [63:0] wc_reg, wc_next;
    logic [63:0] ws_reg, ws_next;
    pkt_t        pkt_reg, pkt_next;

    logic        match;
    logic [40:0] area_sum;
    logic [39:0] area_sat;
    logic [63:0] wc_sat;
    logic [63:0] ws_sat;
    logic [63:0] wc_raw;
    logic [63:0] ws_raw;

    assign match = valid_reg && (key_reg == pkt_in.key);

    // Saturating accumulation of the area and both weighted sums.
    always_comb
    begin
        area_sum = {1'b0, area_reg} + {1'b0, pkt_in.area};
        area_sat = area_sum[40] ? {40{1'b1}} : area_sum[39:0];
        wc_raw   = wc_reg + pkt_in.wc;
        ws_raw   = ws_reg + pkt_in.ws;
        wc_sat   = wc_raw;
        ws_sat   = ws_raw;
        if ((wc_reg[63] == pkt_in.wc[63]) && (wc_raw[63] != wc_reg[63]))
        begin
            wc_sat = wc_reg[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        if ((ws_reg[63] == pkt_in.ws[63]) && (ws_raw[63] != ws_reg[63]))
        begin
            ws_sat = ws_reg[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
    end

    // Entry update and packet forwarding.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        area_next  = area_reg;
        wc_next    = wc_reg;
        ws_next    = ws_reg;
        pkt_next   = pkt_in;
        if (pkt_in.vld)
        begin
            case (pkt_in.cmd)
                CMD_ADD:
                begin
                    // Valid entries form a prefix, so the first free cell
                    // is reached only after every key has been compared.
                    if (!pkt_in.done && (match || !valid_reg))
                    begin
                        valid_next     = 1'b1;
                        key_next       = pkt_in.key;
                        area_next      = area_sat;
                        wc_next        = wc_sat;
                        ws_next        = ws_sat;
                        pkt_next.done  = 1'b1;
                        pkt_next.found = match;
                    end
                end
                CMD_QUERY:
                begin
                    if (!pkt_in.done && match)
                    begin
                        pkt_next.done  = 1'b1;
                        pkt_next.found = 1'b1;
                        pkt_next.area  = area_reg;
                        pkt_next.wc    = wc_reg;
                        pkt_next.ws    = ws_reg;
                    end
                end
                CMD_CLEAR:
                begin
                    area_next = '0;
                    wc_next   = '0;
                    ws_next   = '0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    // Control and sums are cleared at reset; the key is read only when valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            area_reg  <= '0;
            wc_reg    <= '0;
            ws_reg    <= '0;
            pkt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            area_reg  <= area_next;
            wc_reg    <= wc_next;
            ws_reg    <= ws_next;
            pkt_reg   <= pkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign pkt_out = pkt_reg;

endmodule

>>> rtl/core/kwat_div.sv
// ----------------------------------------------------------------------------
// kwat_div: dual restoring divider
// Divides both weighted sums by the area sum one quotient bit per cycle,
// truncating toward zero and saturating to the signed 24-bit range.
// ----------------------------------------------------------------------------
module kwat_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dvd_c,
    input  logic [63:0] dvd_s,
    input  logic [39:0] divisor,
    output logic        done,
    output logic [23:0] quo_c,
    output logic [23:0] quo_s
);
    import kwat_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [40:0] rc_reg, rc_next;
    logic [40:0] rs_reg, rs_next;
    logic [63:0] qc_reg, qc_next;
    logic [63:0] qs_reg, qs_next;
    logic [39:0] div_reg, div_next;
    logic        negc_reg, negc_next;
    logic        negs_reg, negs_next;

    logic [40:0] tc;
    logic [40:0] ts;

    // One restoring step per cycle for each lane.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rc_next   = rc_reg;
        rs_next   = rs_reg;
        qc_next   = qc_reg;
        qs_next   = qs_reg;
        div_next  = div_reg;
        negc_next = negc_reg;
        negs_next = negs_reg;
        tc        = {rc_reg[39:0], qc_reg[63]};
        ts        = {rs_reg[39:0], qs_reg[63]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rc_next   = '0;
            rs_next   = '0;
            negc_next = dvd_c[63];
            negs_next = dvd_s[63];
            qc_next   = dvd_c[63] ? (64'd0 - dvd_c) : dvd_c;
            qs_next   = dvd_s[63] ? (64'd0 - dvd_s) : dvd_s;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (tc >= {1'b0, div_reg})
            begin
                rc_next = tc - {1'b0, div_reg};
                qc_next = {qc_reg[62:0], 1'b1};
            end
            else
            begin
                rc_next = tc;
                qc_next = {qc_reg[62:0], 1'b0};
            end
            if (ts >= {1'b0, div_reg})
            begin
                rs_next = ts - {1'b0, div_reg};
                qs_next = {qs_reg[62:0], 1'b1};
            end
            else
            begin
                rs_next = ts;
                qs_next = {qs_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rc_reg   <= rc_next;
        rs_reg   <= rs_next;
        qc_reg   <= qc_next;
        qs_reg   <= qs_next;
        div_reg  <= div_next;
        negc_reg <= negc_next;
        negs_reg <= negs_next;
    end

    // Sign restore with saturation to the output range.
    always_comb
    begin
        if (negc_reg)
        begin
            quo_c = (qc_reg > 64'd8388608) ? OUT_MIN : (24'd0 - qc_reg[23:0]);
        end
        else
        begin
            quo_c = (qc_reg > 64'd8388607) ? OUT_MAX : qc_reg[23:0];
        end
        if (negs_reg)
        begin
            quo_s = (qs_reg > 64'd8388608) ? OUT_MIN : (24'd0 - qs_reg[23:0]);
        end
        else
        begin
            quo_s = (qs_reg > 64'd8388607) ? OUT_MAX : qs_reg[23:0];
        end
    end

    assign done = done_reg;

endmodule

>>> rtl/core/keyed_area_weighted_average_table.sv
// ----------------------------------------------------------------------------
// keyed_area_weighted_average_table: keyed area-weighted average table
// A chain of entry cells aggregates scraps by key; queries are divided out.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries the command in s_axis_tuser and the key, area and
// both components in s_axis_tdata. Each transaction yields exactly one result
// transaction on the output stream: found and status in m_axis_tuser, the two
// averages in m_axis_tdata.
// One item is processed at a time. It walks the row of TABLE_ENTRIES cells, one
// cell per cycle, and its result is then registered in the finishing stage
// before it moves into the output register. A query hit with a nonzero area
// first passes through the 64-step bit-serial divider.
// The next item is accepted once the previous result has moved into the
// output register, even while it still waits there. A stalled receiver holds
// that result; the following item still walks the row, but its result then
// waits in the finishing stage and no further transaction is accepted.
// Reset empties the table and clears every sum at once; no clearing pass runs.
// ----------------------------------------------------------------------------
module keyed_area_weighted_average_table
#(
    parameter int TABLE_ENTRIES = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: plane_id, patch_x, patch_y, patch_size, area,
    // comp_c, comp_s.
    input  logic [135:0] s_axis_tdata,
    // Fields from bit 0: command.
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // Fields from bit 0: avg_c, avg_s.
    output logic [47:0]  m_axis_tdata,
    // Fields from bit 0: found, status.
    output logic [1:0]   m_axis_tuser
);
    import kwat_pkg::*;

    state_t      state_reg, state_next;
    pkt_t        in_pkt_reg, in_pkt_next;
    pkt_t        chain [TABLE_ENTRIES+1];
    pkt_t        tail;
    logic        res_found_reg, res_found_next;
    logic        res_status_reg, res_status_next;
    logic [23:0] res_c_reg, res_c_next;
    logic [23:0] res_s_reg, res_s_next;
    logic        out_vld_reg, out_vld_next;
    logic [1:0]  out_user_reg, out_user_next;
    logic [47:0] out_data_reg, out_data_next;
    logic        div_start;
    logic        div_done;
    logic [23:0] div_c;
    logic [23:0] div_s;
    logic        accept;

    logic signed [24:0] area_s;
    logic signed [47:0] prod_c;
    logic signed [47:0] prod_s;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Input packet with both products formed once at entry.
    always_comb
    begin
        area_s = {1'b0, s_axis_tdata[87:64]};
        prod_c = area_s * $signed(s_axis_tdata[111:88]);
        prod_s = area_s * $signed(s_axis_tdata[135:112]);
        in_pkt_next       = '0;
        in_pkt_next.vld   = accept;
        in_pkt_next.cmd   = cmd_t'(s_axis_tuser);
        in_pkt_next.key   = {s_axis_tdata[15:0], s_axis_tdata[31:16],
                             s_axis_tdata[47:32], s_axis_tdata[63:48]};
        in_pkt_next.area  = {16'd0, s_axis_tdata[87:64]};
        in_pkt_next.wc    = {{16{prod_c[47]}}, prod_c};
        in_pkt_next.ws    = {{16{prod_s[47]}}, prod_s};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pkt_reg <= '0;
        end
        else
        begin
            in_pkt_reg <= in_pkt_next;
        end
    end

    // Row of entry cells.
    assign chain[0] = in_pkt_reg;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        kwat_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .pkt_in  (chain[i]),
            .pkt_out (chain[i+1])
        );
    end

    assign tail = chain[TABLE_ENTRIES];

    kwat_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dvd_c   (tail.wc),
        .dvd_s   (tail.ws),
        .divisor (tail.area),
        .done    (div_done),
        .quo_c   (div_c),
        .quo_s   (div_s)
    );

    // Finishing control: result build, optional division, output hand-off.
    always_comb
    begin
        state_next      = state_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_c_next      = res_c_reg;
        res_s_next      = res_s_reg;
        out_vld_next    = out_vld_reg;
        out_user_next   = out_user_reg;
        out_data_next   = out_data_reg;
        div_start       = 1'b0;
        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (tail.vld)
                begin
                    res_found_next  = 1'b0;
                    res_status_next = 1'b0;
                    res_c_next      = '0;
                    res_s_next      = '0;
                    state_next      = ST_HOLD;
                    if (tail.cmd == CMD_ADD)
                    begin
                        res_found_next  = tail.found;
                        res_status_next = !tail.done;
                    end
                    else if (tail.cmd == CMD_QUERY)
                    begin
                        res_found_next = tail.found;
                        if (tail.found && (tail.area != '0))
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_c_next = div_c;
                    res_s_next = div_s;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_user_next = {res_status_reg, res_found_reg};
                    out_data_next = {res_s_reg, res_c_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        res_c_reg      <= res_c_next;
        res_s_reg      <= res_s_next;
        out_user_reg   <= out_user_next;
        out_data_reg   <= out_data_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
